@@ design/wbps_pkg.sv @@
package wbps_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	// Configuration port geometry.
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int LEN_RAW_W   = 5;
	localparam int LIMIT_W     = 16;
	localparam int CARE_RAW_W  = 16;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LIMIT  = 3'd4;

	// Bytes held by each pattern register.
	localparam int BYTES_PER_REG = 8;

	localparam int MATCH_OFFSET_W = 32;
	localparam int MATCH_NUMBER_W = 16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_t;

	typedef struct packed {
		logic [MATCH_OFFSET_W-1:0] match_offset;
		logic [MATCH_NUMBER_W-1:0] match_number;
	} out_t;

endpackage

@@ design/wbps_match.sv @@
module wbps_match #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  logic [MAX_PATTERN-1:0][7:0] window,
	input  logic [MAX_PATTERN-1:0][7:0] pattern,
	input  logic [MAX_PATTERN-1:0]      care,
	input  logic [LEN_W-1:0]            len,
	output logic                        hit
);
	import wbps_pkg::*;

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [LEN_W-1:0]       len_m1;
	logic [MAX_PATTERN-1:0] byte_ok;

	assign len_m1 = len - LEN_W'(1);

	// Pattern byte j lines up with the window entry received len-1-j bytes ago.
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_byte
		logic [LEN_W-1:0] pos_full;
		logic [IDX_W-1:0] pos;

		assign pos_full = len_m1 - LEN_W'(j);
		assign pos      = pos_full[IDX_W-1:0];
		assign byte_ok[j] = (LEN_W'(j) >= len) || !care[j] || (window[pos] == pattern[j]);
	end

	assign hit = &byte_ok;

endmodule

@@ design/wildcard_byte_pattern_search_unit.sv @@
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+----------------------------------
// in       | input     | in_valid / in_ready    | in_data   (data_byte, first_byte)
// out      | output    | out_valid / out_ready  | out_data  (match_offset, match_number)
// cfg      | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// The window compare, the offset check and the match count update sit between
// the state registers and the output register, so one byte is accepted per clock
// while the output side keeps taking results.
// A match appears on out_data the cycle after its byte is accepted.
// Reset clears the offset, the match count and the output valid; registers
// come back with the pattern at zero, all bytes cared for and a length of one.
// When a result waits on out_ready, in_ready drops until the output register frees.
module wildcard_byte_pattern_search_unit #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  wbps_pkg::in_t                              in_data,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output wbps_pkg::out_t                             out_data,
	input  logic                                       cfg_we,
	input  logic [wbps_pkg::CFG_INDEX_W-1:0]           cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]            cfg_data
);
	import wbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int EXT_W = (OFFSET_BITS > MATCH_OFFSET_W) ? OFFSET_BITS : MATCH_OFFSET_W;
	localparam logic [OFFSET_BITS-1:0]    OFFSET_MAX = {OFFSET_BITS{1'b1}};
	localparam logic [MATCH_NUMBER_W-1:0] COUNT_MAX  = {MATCH_NUMBER_W{1'b1}};

	// Configuration registers. Only the pattern bytes that fit the window are kept.
	logic [MAX_PATTERN-1:0][7:0] pattern_q;
	logic [MAX_PATTERN-1:0]      care_q;
	logic [LEN_RAW_W-1:0]        len_raw_q;
	logic [LIMIT_W-1:0]          limit_q;

	// Scan state. The window needs no reset: a compare only looks at entries
	// that arrived in the current file, which the offset check guarantees.
	logic [MAX_PATTERN-1:0][7:0] window_q;
	logic [OFFSET_BITS-1:0]      offset_q;
	logic [MATCH_NUMBER_W-1:0]   count_q;

	// Output register.
	logic out_valid_q;
	out_t out_q;

	logic                        in_fire;
	logic [MAX_PATTERN-1:0][7:0] window_next;
	logic [LEN_W-1:0]            len_eff;
	logic [LEN_W-1:0]            len_m1;
	logic [OFFSET_BITS-1:0]      offset_cur;
	logic [MATCH_NUMBER_W-1:0]   count_cur;
	logic [MATCH_NUMBER_W-1:0]   count_next;
	logic [OFFSET_BITS-1:0]      start;
	logic [EXT_W-1:0]            start_ext;
	logic                        window_full;
	logic                        pattern_hit;
	logic                        limit_hit;
	logic                        report;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A new file starts from offset zero and no matches.
	assign offset_cur = in_data.first_byte ? '0 : offset_q;
	assign count_cur  = in_data.first_byte ? '0 : count_q;

	// The new byte enters at entry zero; older bytes move up by one.
	assign window_next[0] = in_data.data_byte;
	for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_shift
		assign window_next[k] = window_q[k-1];
	end

	// A length of zero behaves as one, and anything past the window as its depth.
	always_comb begin
		if (len_raw_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_raw_q > LEN_RAW_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = LEN_W'(len_raw_q);
		end
	end

	assign len_m1      = len_eff - LEN_W'(1);
	assign window_full = offset_cur >= OFFSET_BITS'(len_m1);
	assign start       = offset_cur - OFFSET_BITS'(len_m1);
	assign start_ext   = EXT_W'(start);

	wbps_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_match (
		.window  (window_next),
		.pattern (pattern_q),
		.care    (care_q),
		.len     (len_eff),
		.hit     (pattern_hit)
	);

	// Once a nonzero limit is reached, further matches are dropped and the
	// count holds. The count itself sticks at its maximum.
	assign limit_hit  = (limit_q != '0) && (count_cur >= limit_q);
	assign report     = window_full && pattern_hit && !limit_hit;
	assign count_next = (count_cur == COUNT_MAX) ? COUNT_MAX : count_cur + MATCH_NUMBER_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			care_q    <= '1;
			len_raw_q <= LEN_RAW_W'(1);
			limit_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW: begin
					for (int i = 0; i < MAX_PATTERN; i++) begin
						if (i < BYTES_PER_REG) begin
							pattern_q[i] <= cfg_data[8*i +: 8];
						end
					end
				end
				REG_PATTERN_HIGH: begin
					for (int i = 0; i < MAX_PATTERN; i++) begin
						if (i >= BYTES_PER_REG) begin
							pattern_q[i] <= cfg_data[8*(i-BYTES_PER_REG) +: 8];
						end
					end
				end
				REG_CARE_MASK:   care_q    <= cfg_data[MAX_PATTERN-1:0];
				REG_PATTERN_LEN: len_raw_q <= cfg_data[LEN_RAW_W-1:0];
				REG_MATCH_LIMIT: limit_q   <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			offset_q    <= (offset_cur == OFFSET_MAX) ? OFFSET_MAX
			                                          : offset_cur + OFFSET_BITS'(1);
			count_q     <= report ? count_next : count_cur;
			out_valid_q <= report;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			window_q <= window_next;
			if (report) begin
				out_q.match_offset <= start_ext[MATCH_OFFSET_W-1:0];
				out_q.match_number <= count_next;
			end
		end
	end

endmodule
